// ===== hdl/hpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpdd_pkg
// Shared widths, reset values, register indexes and helpers for the heading
// PID differential-drive controller.
// ----------------------------------------------------------------------------
package hpdd_pkg;

  localparam int unsigned ANGLE_BITS     = 20;
  localparam int unsigned GAIN_FRAC_BITS = 12;
  localparam int unsigned SUM_BITS       = 40;
  localparam int unsigned SUM_LO_BITS    = SUM_BITS / 2;
  localparam int unsigned SUM_HI_BITS    = SUM_BITS - SUM_LO_BITS;
  localparam int unsigned SLOPE_BITS     = ANGLE_BITS + 1;
  localparam int unsigned GAIN_BITS      = 16;
  localparam int unsigned DUTY_BITS      = 8;
  localparam int unsigned OUT_SHIFT      = GAIN_FRAC_BITS + 8;

  // products, signed, gains zero-extended by one bit
  localparam int unsigned PE_BITS  = GAIN_BITS + 1 + ANGLE_BITS;
  localparam int unsigned PD_BITS  = GAIN_BITS + 1 + SLOPE_BITS;
  localparam int unsigned PIL_BITS = GAIN_BITS + 1 + SUM_LO_BITS + 1;
  localparam int unsigned PIH_BITS = GAIN_BITS + 1 + SUM_HI_BITS;
  localparam int unsigned S_BITS   = GAIN_BITS + SUM_BITS + 2;

  // correction magnitude is saturated: beyond this any duty is clamped anyway
  localparam int unsigned CORR_BITS = DUTY_BITS + 2;
  localparam int unsigned RAW_BITS  = DUTY_BITS + 4;

  localparam int unsigned IN_TDATA_BITS  = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_BITS = 2 * DUTY_BITS;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = GAIN_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BASE_SPEED = 3'd0,
    REG_OFFSET_B   = 3'd1,
    REG_GAIN_P     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_GAIN_D     = 3'd4,
    REG_DEAD_BAND  = 3'd5,
    REG_LIMIT_A    = 3'd6,
    REG_LIMIT_B    = 3'd7
  } cfg_reg_e;

  localparam logic [DUTY_BITS-1:0] RST_BASE_SPEED = 8'd150;
  localparam logic [DUTY_BITS-1:0] RST_OFFSET_B   = 8'd25;
  localparam logic [GAIN_BITS-1:0] RST_GAIN_P     = 16'd5066;
  localparam logic [GAIN_BITS-1:0] RST_GAIN_I     = 16'd6445;
  localparam logic [GAIN_BITS-1:0] RST_GAIN_D     = 16'd238;
  localparam logic [GAIN_BITS-1:0] RST_DEAD_BAND  = 16'd512;
  localparam logic [DUTY_BITS-1:0] RST_LIMIT_A    = 8'd255;
  localparam logic [DUTY_BITS-1:0] RST_LIMIT_B    = 8'd230;

  function automatic logic [DUTY_BITS-1:0] clamp_duty(
    input logic signed [RAW_BITS-1:0] v,
    input logic [DUTY_BITS-1:0]       lim
  );
    logic signed [RAW_BITS-1:0] lim_s;
    lim_s = $signed({{(RAW_BITS-DUTY_BITS){1'b0}}, lim});
    if (v > lim_s) begin
      return lim;
    end else if (v <= 0) begin
      return '0;
    end else begin
      return v[DUTY_BITS-1:0];
    end
  endfunction

endpackage

// ===== hdl/heading_pid_differential_drive.sv =====
// ----------------------------------------------------------------------------
// heading_pid_differential_drive
// Heading PID with saturating integral; drives two wheel duties.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)                       transfer
//  s_axis    in   tdata: yaw_angle[19:0], pad; tuser: pause  tvalid & tready
//  m_axis    out  tdata: duty_a[7:0], duty_b[15:8];          tvalid & tready
//                 tuser: in_dead_band
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i            cfg_we_i
//
//  One item per cycle while the pipeline is not held; after its transaction
//  (whose edge loads the operand register with the updated state) a result
//  passes through products, sum, and scale/clamp into the output register.
//  The whole pipeline holds while the output register is full and not taken.
//  Paused transactions are consumed and give no result.
//  Reset restores register defaults and clears sum, previous error and slope.
// ----------------------------------------------------------------------------
module heading_pid_differential_drive (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [hpdd_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,   // yaw_angle
  input  logic                                 s_axis_tuser,   // pause
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [hpdd_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,   // duty_a, duty_b
  output logic                                 m_axis_tuser,   // in_dead_band
  input  logic                                 cfg_we_i,
  input  logic [hpdd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [hpdd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  localparam int unsigned AB = hpdd_pkg::ANGLE_BITS;
  localparam int unsigned SB = hpdd_pkg::SUM_BITS;
  localparam int unsigned LB = hpdd_pkg::SUM_LO_BITS;
  localparam int unsigned DB = hpdd_pkg::SLOPE_BITS;
  localparam int unsigned GB = hpdd_pkg::GAIN_BITS;
  localparam int unsigned WB = hpdd_pkg::DUTY_BITS;
  localparam int unsigned XB = hpdd_pkg::S_BITS;
  localparam int unsigned CB = hpdd_pkg::CORR_BITS;
  localparam int unsigned RB = hpdd_pkg::RAW_BITS;
  localparam int unsigned MB = XB - hpdd_pkg::OUT_SHIFT;

  // configuration registers
  logic [WB-1:0] base_speed_q, offset_b_q, limit_a_q, limit_b_q;
  logic [GB-1:0] gain_p_q, gain_i_q, gain_d_q, dead_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= hpdd_pkg::RST_BASE_SPEED;
      offset_b_q   <= hpdd_pkg::RST_OFFSET_B;
      gain_p_q     <= hpdd_pkg::RST_GAIN_P;
      gain_i_q     <= hpdd_pkg::RST_GAIN_I;
      gain_d_q     <= hpdd_pkg::RST_GAIN_D;
      dead_band_q  <= hpdd_pkg::RST_DEAD_BAND;
      limit_a_q    <= hpdd_pkg::RST_LIMIT_A;
      limit_b_q    <= hpdd_pkg::RST_LIMIT_B;
    end else if (cfg_we_i) begin
      case (hpdd_pkg::cfg_reg_e'(cfg_idx_i))
        hpdd_pkg::REG_BASE_SPEED: base_speed_q <= cfg_data_i[WB-1:0];
        hpdd_pkg::REG_OFFSET_B:   offset_b_q   <= cfg_data_i[WB-1:0];
        hpdd_pkg::REG_GAIN_P:     gain_p_q     <= cfg_data_i;
        hpdd_pkg::REG_GAIN_I:     gain_i_q     <= cfg_data_i;
        hpdd_pkg::REG_GAIN_D:     gain_d_q     <= cfg_data_i;
        hpdd_pkg::REG_DEAD_BAND:  dead_band_q  <= cfg_data_i;
        hpdd_pkg::REG_LIMIT_A:    limit_a_q    <= cfg_data_i[WB-1:0];
        hpdd_pkg::REG_LIMIT_B:    limit_b_q    <= cfg_data_i[WB-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic out_vld_q, adv, acc, upd;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;
  assign upd           = acc && !s_axis_tuser;

  // state update at the transaction
  logic signed [AB-1:0] e_in;
  logic                 e_zero;
  logic signed [SB-1:0] sum_q, sum_d;
  logic signed [AB-1:0] prev_q;
  logic signed [DB-1:0] slope_q, slope_d;
  logic signed [SB:0]   sum_ext;
  logic [AB-1:0]        e_mag;
  logic                 in_band;

  assign e_in    = $signed(s_axis_tdata[AB-1:0]);
  assign e_zero  = (e_in == '0);
  assign sum_ext = {sum_q[SB-1], sum_q} + {{(SB-AB+1){e_in[AB-1]}}, e_in};
  assign e_mag   = e_in[AB-1] ? AB'(-e_in) : e_in;
  assign in_band = {{(AB > GB ? 0 : GB-AB){1'b0}}, e_mag} <
                   {{(AB > GB ? AB-GB : 0){1'b0}}, dead_band_q};

  always_comb begin
    sum_d   = sum_q;
    slope_d = slope_q;
    if (e_zero) begin
      sum_d = '0;
    end else begin
      if (sum_ext[SB] != sum_ext[SB-1]) begin
        sum_d = {sum_ext[SB], {(SB-1){!sum_ext[SB]}}};
      end else begin
        sum_d = sum_ext[SB-1:0];
      end
      slope_d = {e_in[AB-1], e_in} - {prev_q[AB-1], prev_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      prev_q  <= '0;
      slope_q <= '0;
    end else if (upd) begin
      sum_q   <= sum_d;
      prev_q  <= e_in;
      slope_q <= slope_d;
    end
  end

  // stage A: operands
  logic                 a_vld_q, a_nom_q, a_band_q;
  logic signed [AB-1:0] a_e_q;
  logic signed [SB-1:0] a_sum_q;
  logic signed [DB-1:0] a_slope_q;

  // stage B: products
  logic                         b_vld_q, b_nom_q, b_band_q;
  logic signed [hpdd_pkg::PE_BITS-1:0]  b_pe_q;
  logic signed [hpdd_pkg::PD_BITS-1:0]  b_pd_q;
  logic signed [hpdd_pkg::PIL_BITS-1:0] b_pil_q;
  logic signed [hpdd_pkg::PIH_BITS-1:0] b_pih_q;

  // stage C: sum
  logic                 c_vld_q, c_nom_q, c_band_q;
  logic signed [XB-1:0] c_s_q, c_s_d;

  logic signed [GB:0] gp_s, gi_s, gd_s;
  assign gp_s = $signed({1'b0, gain_p_q});
  assign gi_s = $signed({1'b0, gain_i_q});
  assign gd_s = $signed({1'b0, gain_d_q});

  assign c_s_d = XB'(b_pe_q) + XB'(b_pd_q) + XB'(b_pil_q) + (XB'(b_pih_q) <<< LB);

  // stage D: scale, correct, clamp
  logic [XB-1:0]        s_mag;
  logic [MB-1:0]        t_mag;
  logic [CB-1:0]        t_sat;
  logic signed [RB-1:0] t_s, nom_b, raw_a, raw_b, base_s;

  assign s_mag  = c_s_q[XB-1] ? XB'(-c_s_q) : c_s_q;
  assign t_mag  = s_mag[XB-1:hpdd_pkg::OUT_SHIFT];
  assign t_sat  = (|t_mag[MB-1:CB-1]) ? {1'b0, {(CB-1){1'b1}}} : t_mag[CB-1:0];
  assign t_s    = c_s_q[XB-1] ? -$signed(RB'(t_sat)) : $signed(RB'(t_sat));
  assign base_s = $signed(RB'(base_speed_q));
  assign nom_b  = base_s - $signed(RB'(offset_b_q));
  assign raw_a  = c_nom_q ? base_s : base_s - t_s;
  assign raw_b  = c_nom_q ? nom_b : nom_b + t_s;

  logic [WB-1:0] duty_a_q, duty_b_q;
  logic          band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= upd;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      out_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_e_q     <= e_in;
      a_sum_q   <= sum_d;
      a_slope_q <= slope_d;
      a_nom_q   <= in_band || e_zero;
      a_band_q  <= in_band;

      b_pe_q   <= gp_s * a_e_q;
      b_pd_q   <= gd_s * a_slope_q;
      b_pil_q  <= gi_s * $signed({1'b0, a_sum_q[LB-1:0]});
      b_pih_q  <= gi_s * $signed(a_sum_q[SB-1:LB]);
      b_nom_q  <= a_nom_q;
      b_band_q <= a_band_q;

      c_s_q    <= c_s_d;
      c_nom_q  <= b_nom_q;
      c_band_q <= b_band_q;

      duty_a_q <= hpdd_pkg::clamp_duty(raw_a, limit_a_q);
      duty_b_q <= hpdd_pkg::clamp_duty(raw_b, limit_b_q);
      band_q   <= c_band_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {duty_b_q, duty_a_q};
  assign m_axis_tuser  = band_q;

endmodule
